### hdl/sps_pkg.sv
// Package for the subtitle program-stream pack framer.
// Holds the pack geometry, stream codes and the command word passed between the front
// and back halves. No dependencies.
`timescale 1ns / 1ps
package sps_pkg;

   localparam int PACK_BYTES      = 2048;
   localparam int MAX_UNIT_BYTES  = 65535;
   localparam int PS_HDR_BYTES    = 14;
   localparam int FIRST_PES_BYTES = 15;
   localparam int NEXT_PES_BYTES  = 10;
   localparam int ROOM_FIRST      = PACK_BYTES - PS_HDR_BYTES - FIRST_PES_BYTES;
   localparam int ROOM_NEXT       = PACK_BYTES - PS_HDR_BYTES - NEXT_PES_BYTES;
   localparam int MIN_UNIT_BYTES  = 4;
   localparam int MIN_PAD_PACKET  = 6;
   localparam int SCR_DIVISOR     = 100000;
   localparam int SCR_MULT        = 9;
   localparam int QUEUE_DEPTH     = 4;

   localparam logic [7:0] SC_PACK    = 8'hBA;
   localparam logic [7:0] SC_PRIV1   = 8'hBD;
   localparam logic [7:0] SC_PADDING = 8'hBE;
   localparam logic [7:0] PES_FLAGS1 = 8'h81;
   localparam logic [7:0] PES_PTS    = 8'h80;
   localparam logic [7:0] MUX_RATE0  = 8'h01;
   localparam logic [7:0] MUX_RATE1  = 8'h89;
   localparam logic [7:0] MUX_RATE2  = 8'hC3;
   localparam logic [7:0] PACK_STUFF = 8'hF8;
   localparam logic [7:0] FILL_BYTE  = 8'hFF;
   localparam logic [5:0] SID_RESET  = 6'h20;

   // One accepted byte that produces output, with everything the back half needs.
   typedef struct packed {
      logic [7:0]  data;
      logic        hdr;       // pack and PES header precede the byte
      logic        first;     // header carries a PTS
      logic [11:0] chunk;     // payload bytes in this pack
      logic [2:0]  stuff;     // PES stuffing bytes
      logic        unit_end;  // last byte of the unit
      logic        padpkt;    // padding packet follows
      logic [10:0] plen;      // padding packet payload length
      logic [32:0] ticks;     // 90 kHz clock of the unit
   } sps_cmd_type;

endpackage

### hdl/sps_ifs.sv
// Channel interfaces of the pack framer: input words, result words, register write.
// Depends on nothing.
`timescale 1ns / 1ps
interface sps_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        unit_start;
   logic [15:0] unit_length;
   logic [57:0] timestamp_ns;
   modport source(output valid, data_byte, unit_start, unit_length, timestamp_ns,
                  input ready);
   modport sink(input valid, data_byte, unit_start, unit_length, timestamp_ns,
                output ready);
endinterface

interface sps_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic [11:0] repeat_count;
   logic        item_done;
   logic        unit_done;
   modport source(output valid, out_byte, repeat_count, item_done, unit_done,
                  input ready);
   modport sink(input valid, out_byte, repeat_count, item_done, unit_done,
                output ready);
endinterface

interface sps_csr_if;
   logic       valid;
   logic       ready;
   logic [5:0] substream_id;
   modport source(output valid, substream_id, input ready);
   modport sink(input valid, substream_id, output ready);
endinterface

### hdl/sps_front.sv
// Front half: accepts words, converts the unit timestamp to 90 kHz ticks with a
// digit-serial divider (eight quotient bits per cycle), tracks pack state and issues
// commands. Depends on sps_pkg.
`timescale 1ns / 1ps
module sps_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [7:0]          in_byte,
   input  logic                in_start,
   input  logic [15:0]         in_length,
   input  logic [57:0]         in_ts,
   input  logic                q_full,
   output logic                push,
   output sps_pkg::sps_cmd_type push_cmd
);

   // The divisor 100000 is 32 * 3125: the power of two is a shift, and the odd part
   // is divided one byte digit at a time by reciprocal multiplication.
   localparam int SCR_SHIFT = 5;
   localparam int DIV_ODD   = sps_pkg::SCR_DIVISOR / (1 << SCR_SHIFT);
   localparam int DIGITS    = 8;
   localparam logic [20:0] RECIP =
      21'(((64'd1 << 32) + 64'(DIV_ODD) - 64'd1) / 64'(DIV_ODD));

   logic        pend_ff, pend_in;
   logic [7:0]  byte_ff;
   logic        start_ff;
   logic [15:0] len_ff;
   logic        div_run_ff;
   logic [2:0]  div_cnt_ff;
   logic [63:0] dvd_ff;
   logic [11:0] rem_ff, rem_in;
   logic [32:0] quo_ff;
   logic [32:0] ticks_ff, ticks_in;
   logic [15:0] left_ff, left_in;
   logic [11:0] chunk_ff, chunk_in;
   logic [10:0] pad_ff, pad_in;
   logic        first_ff, first_in;
   logic        skip_ff, skip_in;

   logic        accept, go, start_ok, emit, newhdr, last, fin;
   logic [15:0] bl, bl_dec, skip_left;
   logic        first_v;
   logic [11:0] chunk_v, room, chunk_n;
   logic [10:0] pad_v, pad_n;
   logic [2:0]  stuff;
   logic [63:0] ts9;
   logic [19:0] part;
   logic [39:0] prod;
   logic [7:0]  qd;
   logic [19:0] qsub;

   assign go       = pend_ff && !div_run_ff && !q_full;
   assign in_ready = !pend_ff || go;
   assign accept   = in_valid && in_ready;
   assign pend_in  = accept ? 1'b1 : (go ? 1'b0 : pend_ff);

   // One quotient digit: the partial remainder never exceeds 3125 * 256, so the
   // reciprocal product fits in 40 bits and its digit is exact.
   assign ts9    = ({6'd0, in_ts} << 3) + {6'd0, in_ts};
   assign part   = {rem_ff, dvd_ff[63:56]};
   assign prod   = 40'(part) * 40'(RECIP);
   assign qd     = prod[39:32];
   assign qsub   = 20'(qd) * 20'(DIV_ODD);
   assign rem_in = 12'(part - qsub);

   always_comb begin
      start_ok = (len_ff >= 16'(sps_pkg::MIN_UNIT_BYTES)) &&
                 (len_ff <= 16'(sps_pkg::MAX_UNIT_BYTES));
      bl      = start_ff ? len_ff : left_ff;
      first_v = start_ff ? 1'b1 : first_ff;
      chunk_v = start_ff ? 12'd0 : chunk_ff;
      pad_v   = start_ff ? 11'd0 : pad_ff;
      emit    = start_ff ? start_ok : (left_ff != 16'd0 && !skip_ff);
      newhdr  = chunk_v == 12'd0;
      room    = first_v ? 12'(sps_pkg::ROOM_FIRST) : 12'(sps_pkg::ROOM_NEXT);
      last    = bl <= {4'd0, room};
      pad_n   = newhdr ? (last ? 11'(room - bl[11:0]) : 11'd0) : pad_v;
      chunk_n = newhdr ? (last ? bl[11:0] : room) : chunk_v;
      stuff   = (newhdr && last && pad_n < 11'(sps_pkg::MIN_PAD_PACKET)) ? pad_n[2:0] : 3'd0;
      bl_dec  = bl - 16'd1;
      fin     = bl_dec == 16'd0;
      skip_left = (len_ff != 16'd0) ? len_ff - 16'd1 : 16'd0;

      push_cmd.data     = byte_ff;
      push_cmd.hdr      = newhdr;
      push_cmd.first    = first_v;
      push_cmd.chunk    = chunk_n;
      push_cmd.stuff    = stuff;
      push_cmd.unit_end = fin;
      push_cmd.padpkt   = fin && pad_n >= 11'(sps_pkg::MIN_PAD_PACKET);
      push_cmd.plen     = pad_n - 11'(sps_pkg::MIN_PAD_PACKET);
      push_cmd.ticks    = start_ff ? quo_ff : ticks_ff;
      push = go && emit;

      ticks_in = ticks_ff;
      left_in  = left_ff;
      chunk_in = chunk_ff;
      pad_in   = pad_ff;
      first_in = first_ff;
      skip_in  = skip_ff;
      if (go) begin
         if (start_ff) begin
            ticks_in = quo_ff;
         end
         if (start_ff && !start_ok) begin
            left_in  = skip_left;
            skip_in  = skip_left != 16'd0;
            chunk_in = 12'd0;
            pad_in   = 11'd0;
            first_in = 1'b1;
         end else if (!start_ff && skip_ff && left_ff != 16'd0) begin
            left_in = left_ff - 16'd1;
            skip_in = (left_ff - 16'd1) != 16'd0;
         end else if (emit) begin
            skip_in  = 1'b0;
            left_in  = bl_dec;
            first_in = newhdr ? 1'b0 : first_v;
            chunk_in = fin ? 12'd0 : chunk_n - 12'd1;
            pad_in   = fin ? 11'd0 : pad_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= 1'b0;
         div_run_ff <= 1'b0;
         ticks_ff   <= '0;
         left_ff    <= '0;
         chunk_ff   <= '0;
         pad_ff     <= '0;
         first_ff   <= 1'b0;
         skip_ff    <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         ticks_ff <= ticks_in;
         left_ff  <= left_in;
         chunk_ff <= chunk_in;
         pad_ff   <= pad_in;
         first_ff <= first_in;
         skip_ff  <= skip_in;
         if (accept && in_start) begin
            div_run_ff <= 1'b1;
         end else if (div_run_ff && div_cnt_ff == 3'(DIGITS - 1)) begin
            div_run_ff <= 1'b0;
         end
      end
   end

   // Long division of ts * 9 / 32 by 3125, one byte digit per cycle; only the low 33
   // quotient bits are kept.
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff  <= in_byte;
         start_ff <= in_start;
         len_ff   <= in_length;
      end
      if (accept && in_start) begin
         dvd_ff     <= ts9 >> SCR_SHIFT;
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (div_run_ff) begin
         dvd_ff     <= {dvd_ff[55:0], 8'd0};
         rem_ff     <= rem_in;
         quo_ff     <= {quo_ff[24:0], qd};
         div_cnt_ff <= div_cnt_ff + 3'd1;
      end
   end

endmodule

### hdl/sps_queue.sv
// Command queue between front and back halves of the pack framer.
// Depends on sps_pkg. DEPTH must be a power of two.
`timescale 1ns / 1ps
module sps_queue #(
   parameter int DEPTH = sps_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sps_pkg::sps_cmd_type push_cmd,
   output logic                full,
   output logic                head_vld,
   output sps_pkg::sps_cmd_type head,
   input  logic                pop
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   sps_pkg::sps_cmd_type mem [DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [CW-1:0] cnt_ff;

   assign full     = cnt_ff == CW'(DEPTH);
   assign head_vld = cnt_ff != '0;
   assign head     = mem[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + AW'(1);
         end
         if (pop) begin
            rd_ff <= rd_ff + AW'(1);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + CW'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
      end
   end

endmodule

### hdl/sps_back.sv
// Back half: expands one command into pack header, PES header, payload byte and
// padding words, one per cycle into the output register unless stalled. Depends on sps_pkg.
`timescale 1ns / 1ps
module sps_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_vld,
   input  sps_pkg::sps_cmd_type head,
   output logic                pop,
   input  logic [5:0]          sid,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [7:0]          out_byte,
   output logic [11:0]         out_count,
   output logic                out_item_done,
   output logic                out_unit_done
);

   typedef enum logic [3:0] {
      S_BEGIN, S_PACK, S_PES, S_OPT, S_STUFF, S_SID, S_DATA, S_PAD, S_RUN
   } state_type;

   state_type   st_ff, eff, nxt;
   logic [3:0]  sub_ff, nsub;
   logic [7:0]  b;
   logic [11:0] cnt;
   logic        fin, adv;
   logic [15:0] pes_len;
   logic [32:0] c;

   assign c   = head.ticks;
   assign adv = head_vld && (!out_valid || out_ready);
   assign pop = adv && fin;

   always_comb begin
      pes_len = 16'(head.chunk) + (head.first ? 16'd9 : 16'd4) + 16'(head.stuff);
      eff = (st_ff == S_BEGIN) ? (head.hdr ? S_PACK : S_DATA) : st_ff;
      b    = 8'h00;
      cnt  = 12'd1;
      fin  = 1'b0;
      nxt  = eff;
      nsub = sub_ff + 4'd1;
      unique case (eff)
         S_PACK: begin
            case (sub_ff)
               4'd2:    b = 8'h01;
               4'd3:    b = sps_pkg::SC_PACK;
               4'd4:    b = {2'b01, c[32:30], 1'b1, c[29:28]};
               4'd5:    b = c[27:20];
               4'd6:    b = {c[19:15], 1'b1, c[14:13]};
               4'd7:    b = c[12:5];
               4'd8:    b = {c[4:0], 3'b100};
               4'd9:    b = sps_pkg::MUX_RATE0;
               4'd10:   b = sps_pkg::MUX_RATE0;
               4'd11:   b = sps_pkg::MUX_RATE1;
               4'd12:   b = sps_pkg::MUX_RATE2;
               4'd13:   b = sps_pkg::PACK_STUFF;
               default: b = 8'h00;
            endcase
            if (sub_ff == 4'd13) begin
               nxt  = S_PES;
               nsub = 4'd0;
            end
         end
         S_PES: begin
            case (sub_ff)
               4'd2:    b = 8'h01;
               4'd3:    b = sps_pkg::SC_PRIV1;
               4'd4:    b = pes_len[15:8];
               4'd5:    b = pes_len[7:0];
               4'd6:    b = sps_pkg::PES_FLAGS1;
               default: b = 8'h00;
            endcase
            if (sub_ff == 4'd6) begin
               nxt  = S_OPT;
               nsub = 4'd0;
            end
         end
         S_OPT: begin
            if (head.first) begin
               case (sub_ff)
                  4'd0:    b = sps_pkg::PES_PTS;
                  4'd1:    b = 8'd5 + 8'(head.stuff);
                  4'd2:    b = {4'b0010, c[32:30], 1'b1};
                  4'd3:    b = c[29:22];
                  4'd4:    b = {c[21:15], 1'b1};
                  4'd5:    b = c[14:7];
                  default: b = {c[6:0], 1'b1};
               endcase
            end else begin
               b = (sub_ff == 4'd0) ? 8'h00 : 8'(head.stuff);
            end
            if (sub_ff == (head.first ? 4'd6 : 4'd1)) begin
               nxt  = (head.stuff != 3'd0) ? S_STUFF : S_SID;
               nsub = 4'd0;
            end
         end
         S_STUFF: begin
            b    = sps_pkg::FILL_BYTE;
            cnt  = 12'(head.stuff);
            nxt  = S_SID;
            nsub = 4'd0;
         end
         S_SID: begin
            b    = {2'b00, sid};
            nxt  = S_DATA;
            nsub = 4'd0;
         end
         S_DATA: begin
            b    = head.data;
            fin  = !head.padpkt;
            nxt  = S_PAD;
            nsub = 4'd0;
         end
         S_PAD: begin
            case (sub_ff)
               4'd2:    b = 8'h01;
               4'd3:    b = sps_pkg::SC_PADDING;
               4'd4:    b = {5'd0, head.plen[10:8]};
               4'd5:    b = head.plen[7:0];
               default: b = 8'h00;
            endcase
            if (sub_ff == 4'd5) begin
               fin  = head.plen == 11'd0;
               nxt  = S_RUN;
               nsub = 4'd0;
            end
         end
         S_RUN: begin
            b   = sps_pkg::FILL_BYTE;
            cnt = 12'(head.plen);
            fin = 1'b1;
         end
         default: begin
            b = 8'h00;
         end
      endcase
      if (fin) begin
         nxt  = S_BEGIN;
         nsub = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_BEGIN;
         sub_ff    <= '0;
         out_valid <= 1'b0;
      end else begin
         if (adv) begin
            st_ff         <= nxt;
            sub_ff        <= nsub;
            out_valid     <= 1'b1;
            out_byte      <= b;
            out_count     <= cnt;
            out_item_done <= fin;
            out_unit_done <= fin && head.unit_end;
         end else if (out_ready) begin
            out_valid <= 1'b0;
         end
      end
   end

endmodule

### hdl/subtitle_ps_pack_framer.sv
// Top level of the subtitle program-stream pack framer.
// Depends on sps_pkg, sps_ifs, sps_front, sps_queue and sps_back.
//
// Usage: one subtitle unit arrives as words on req, one byte per word; the first
// word has unit_start high and carries unit_length and timestamp_ns. The block
// wraps the unit into 2048-byte program-stream packs and emits them on rsp, one
// word per cycle unless rsp stalls, each word a byte with a repeat count (runs of
// stuffing or padding come as one word). item_done marks the last word caused by
// an input word, unit_done the last word of a unit. Units shorter than four bytes
// produce nothing. csr writes the substream id; it is always ready and should only
// be written while the block is idle.
// Throughput: while rsp is ready, a payload byte that opens no pack and adds no
// padding packet yields one output word, and such bytes are taken one per cycle.
// A byte that opens a pack yields up to 32 words at one per cycle; the four-entry
// command queue lets the front run ahead, then req stalls. A unit's first word
// waits in the front for the timestamp divider, which produces eight quotient bits
// per cycle. Words pass the front's input register and the queue to the output
// register. Reset clears all pack state and sets the substream id to 32. When rsp
// stalls the output word holds, the queue fills, and req.ready drops.
`timescale 1ns / 1ps
module subtitle_ps_pack_framer #(
   parameter int QUEUE_DEPTH = sps_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   sps_req_if.sink    req,
   sps_rsp_if.source  rsp,
   sps_csr_if.sink    csr
);

   // Substream id register, written whenever the csr channel handshakes.
   logic [5:0] sid_ff;

   logic                 q_full, push, head_vld, pop;
   sps_pkg::sps_cmd_type push_cmd, head;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sid_ff <= sps_pkg::SID_RESET;
      end else if (csr.valid) begin
         sid_ff <= csr.substream_id;
      end
   end

   // Front half: acceptance, timestamp conversion and pack bookkeeping.
   sps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_byte   (req.data_byte),
      .in_start  (req.unit_start),
      .in_length (req.unit_length),
      .in_ts     (req.timestamp_ns),
      .q_full    (q_full),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   // The queue lets the front keep accepting while a header burst drains.
   sps_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .head_vld (head_vld),
      .head     (head),
      .pop      (pop)
   );

   // Back half: word sequencing into the registered output.
   sps_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_vld      (head_vld),
      .head          (head),
      .pop           (pop),
      .sid           (sid_ff),
      .out_valid     (rsp.valid),
      .out_ready     (rsp.ready),
      .out_byte      (rsp.out_byte),
      .out_count     (rsp.repeat_count),
      .out_item_done (rsp.item_done),
      .out_unit_done (rsp.unit_done)
   );

endmodule

### hdl/sps_checker.sv
// Port-level checks of the pack framer, bound to its top level.
// Depends on subtitle_ps_pack_framer and sps_ifs.
`timescale 1ns / 1ps
module sps_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_byte,
   input logic [11:0] rsp_count,
   input logic        rsp_item_done,
   input logic        rsp_unit_done
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte) && $stable(rsp_count))
      else $error("stalled result word changed");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count != 12'd0)
      else $error("zero repeat count");

   a_unit_ends_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_unit_done |-> rsp_item_done)
      else $error("unit end without item end");

endmodule

bind subtitle_ps_pack_framer sps_checker u_sps_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_byte      (rsp.out_byte),
   .rsp_count     (rsp.repeat_count),
   .rsp_item_done (rsp.item_done),
   .rsp_unit_done (rsp.unit_done)
);

### sim/subtitle_ps_pack_framer_test.sv
// Self-checking testbench for the subtitle program-stream pack framer.
// Depends on sps_pkg and the channel interfaces in sps_ifs; predicts every output word
// with a behavioral model of the packetizer and checks them in order.
`timescale 1ns / 1ps

// Behavioral model of the packetizer. It keeps its own copy of the unit state and the
// substream id, turns each accepted input word into the program-stream words it must
// cause, and matches the output words against them in order.
class ps_word_predictor;

   typedef struct {
      logic [7:0]  out_byte;
      logic [11:0] repeat_count;
      logic        item_done;
      logic        unit_done;
   } ps_word_type;

   ps_word_type stream_words[$];
   int          errors;
   logic [5:0]  sid;
   logic [32:0] ticks;
   int          bytes_left;
   int          chunk_left;
   int          pad_amount;
   bit          first_pack;
   bit          skip_unit;

   function new();
      errors     = 0;
      sid        = sps_pkg::SID_RESET;
      ticks      = '0;
      bytes_left = 0;
      chunk_left = 0;
      pad_amount = 0;
      first_pack = 0;
      skip_unit  = 0;
   endfunction

   function void push(logic [7:0] b, int cnt);
      ps_word_type w;
      w.out_byte     = b;
      w.repeat_count = 12'(cnt);
      w.item_done    = 1'b0;
      w.unit_done    = 1'b0;
      stream_words   = {stream_words, w};
   endfunction

   function void push_pack_header();
      logic [63:0] c;
      c = 64'(ticks);
      push(8'h00, 1);
      push(8'h00, 1);
      push(8'h01, 1);
      push(sps_pkg::SC_PACK, 1);
      push(8'h44 | 8'((c >> 27) & 64'h38) | 8'((c >> 28) & 64'h03), 1);
      push(8'(c >> 20), 1);
      push(8'((c >> 12) & 64'hF8) | 8'h04 | 8'((c >> 13) & 64'h03), 1);
      push(8'(c >> 5), 1);
      push(8'((c << 3) & 64'hF8) | 8'h04, 1);
      push(sps_pkg::MUX_RATE0, 1);
      push(sps_pkg::MUX_RATE0, 1);
      push(sps_pkg::MUX_RATE1, 1);
      push(sps_pkg::MUX_RATE2, 1);
      push(sps_pkg::PACK_STUFF, 1);
   endfunction

   function void push_pes_header(int chunk, int stuff);
      logic [63:0] c;
      int          len;
      c   = 64'(ticks);
      len = first_pack ? chunk + 9 + stuff : chunk + 4 + stuff;
      push(8'h00, 1);
      push(8'h00, 1);
      push(8'h01, 1);
      push(sps_pkg::SC_PRIV1, 1);
      push(8'(len >> 8), 1);
      push(8'(len), 1);
      push(sps_pkg::PES_FLAGS1, 1);
      if (first_pack) begin
         push(sps_pkg::PES_PTS, 1);
         push(8'(5 + stuff), 1);
         push(8'h21 | 8'((c >> 29) & 64'h0E), 1);
         push(8'(c >> 22), 1);
         push(8'((c >> 14) & 64'hFE) | 8'h01, 1);
         push(8'(c >> 7), 1);
         push(8'((c << 1) & 64'hFE) | 8'h01, 1);
      end else begin
         push(8'h00, 1);
         push(8'(stuff), 1);
      end
      if (stuff > 0) push(sps_pkg::FILL_BYTE, stuff);
      push({2'b00, sid}, 1);
   endfunction

   // Notes one accepted input word and queues the words it causes.
   function void note_word(logic [7:0] b, logic start, logic [15:0] len, logic [57:0] ts);
      logic [63:0] scaled;
      int          room;
      int          chunk;
      int          stuff;
      int          plen;
      bit          last;
      int          first_new;
      first_new = stream_words.size();
      if (start) begin
         scaled     = 64'(ts) * 64'(sps_pkg::SCR_MULT);
         scaled     = scaled / 64'(sps_pkg::SCR_DIVISOR);
         ticks      = scaled[32:0];
         chunk_left = 0;
         pad_amount = 0;
         first_pack = 1;
         if (int'(len) < sps_pkg::MIN_UNIT_BYTES || int'(len) > sps_pkg::MAX_UNIT_BYTES) begin
            bytes_left = (len > 16'd0) ? int'(len) - 1 : 0;
            skip_unit  = (bytes_left != 0);
            return;
         end
         skip_unit  = 0;
         bytes_left = int'(len);
      end else begin
         if (bytes_left == 0) return;
         if (skip_unit) begin
            bytes_left--;
            if (bytes_left == 0) skip_unit = 0;
            return;
         end
      end
      if (chunk_left == 0) begin
         room       = first_pack ? sps_pkg::ROOM_FIRST : sps_pkg::ROOM_NEXT;
         last       = (bytes_left <= room);
         chunk      = last ? bytes_left : room;
         pad_amount = last ? room - bytes_left : 0;
         stuff      = (last && pad_amount < sps_pkg::MIN_PAD_PACKET) ? pad_amount : 0;
         push_pack_header();
         push_pes_header(chunk, stuff);
         chunk_left = chunk;
         first_pack = 0;
      end
      push(b, 1);
      chunk_left--;
      bytes_left--;
      if (bytes_left == 0) begin
         if (pad_amount >= sps_pkg::MIN_PAD_PACKET) begin
            plen = pad_amount - sps_pkg::MIN_PAD_PACKET;
            push(8'h00, 1);
            push(8'h00, 1);
            push(8'h01, 1);
            push(sps_pkg::SC_PADDING, 1);
            push(8'(plen >> 8), 1);
            push(8'(plen), 1);
            if (plen > 0) push(sps_pkg::FILL_BYTE, plen);
         end
         pad_amount = 0;
         chunk_left = 0;
         stream_words[$].unit_done = 1'b1;
      end
      if (stream_words.size() > first_new) stream_words[$].item_done = 1'b1;
   endfunction

   // Compares one accepted output word with the oldest predicted word.
   function void check_word(logic [7:0] b, logic [11:0] cnt, logic idone, logic udone);
      ps_word_type w;
      if (stream_words.size() == 0) begin
         $error("unexpected output word: out_byte %h repeat_count %0d", b, cnt);
         errors++;
         return;
      end
      w = stream_words.pop_front();
      if (b !== w.out_byte) begin
         $error("out_byte: expected %h, actual %h", w.out_byte, b);
         errors++;
      end
      if (cnt !== w.repeat_count) begin
         $error("repeat_count: expected %0d, actual %0d", w.repeat_count, cnt);
         errors++;
      end
      if (idone !== w.item_done) begin
         $error("item_done: expected %b, actual %b", w.item_done, idone);
         errors++;
      end
      if (udone !== w.unit_done) begin
         $error("unit_done: expected %b, actual %b", w.unit_done, udone);
         errors++;
      end
   endfunction

endclass

module subtitle_ps_pack_framer_test;

   logic clock;
   logic reset;

   sps_req_if req();
   sps_rsp_if rsp();
   sps_csr_if csr();

   subtitle_ps_pack_framer dut (
      .clock(clock),
      .reset(reset),
      .req  (req.sink),
      .rsp  (rsp.source),
      .csr  (csr.sink)
   );

   ps_word_predictor pack_model;

   // calm turns off all random idling for the last part of the run.
   bit calm;
   // A request from the stimulus to the receiver for one long hold-off.
   bit long_hold_request;
   int words_sent;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // A fixed upper bound on the run; a healthy run ends long before this.
   initial begin
      #(12 * 3_000_000);
      $display("DONE: errors detected");
      $finish;
   end

   // The receiver. Every accepted output word is checked right at the edge where it
   // moves. Ready drops in random bursts, and once on request for a long stretch so
   // that the command queue fills and the block holds its input off.
   initial begin : receiver
      int hold_cycles;
      hold_cycles = 0;
      rsp.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp.valid && rsp.ready)
            pack_model.check_word(rsp.out_byte, rsp.repeat_count, rsp.item_done,
                                  rsp.unit_done);
         if (long_hold_request) begin
            long_hold_request = 0;
            hold_cycles = 600;
            rsp.ready <= 1'b0;
         end else if (hold_cycles > 0) begin
            hold_cycles--;
            rsp.ready <= (hold_cycles == 0);
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            hold_cycles = $urandom_range(1, 16);
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   // Offers one input word and returns at the edge where it is accepted. Valid stays
   // high unless the sender decides to idle afterwards.
   task automatic send_word(logic [7:0] b, logic start, logic [15:0] len, logic [57:0] ts);
      req.valid        <= 1'b1;
      req.data_byte    <= b;
      req.unit_start   <= start;
      req.unit_length  <= len;
      req.timestamp_ns <= ts;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      pack_model.note_word(b, start, len, ts);
      words_sent++;
      if (!calm && $urandom_range(0, 7) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   function automatic logic [57:0] random_ts();
      return 58'({$urandom(), $urandom()});
   endfunction

   // A word that is not the start of a unit. Its length and timestamp fields are
   // don't-care, so they get random values to exercise every bit.
   task automatic send_body(logic [7:0] b);
      send_word(b, 1'b0, 16'($urandom()), random_ts());
   endtask

   // Sends a unit header announcing len bytes, followed by count - 1 body words.
   task automatic send_unit(int len, int count, logic [57:0] ts);
      send_word(8'($urandom()), 1'b1, 16'(len), ts);
      for (int i = 1; i < count; i++) send_body(8'($urandom()));
   endtask

   // Waits until every predicted word has come out, then lets the block settle long
   // enough for a timestamp divide on a swallowed unit to finish.
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pack_model.stream_words.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_substream_id(logic [5:0] id);
      csr.valid        <= 1'b1;
      csr.substream_id <= id;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
      pack_model.sid = id;
   endtask

   // Random units, mostly well formed and small, with some short, truncated and
   // stray traffic mixed in.
   task automatic random_units(int words);
      int stop_at;
      int pick;
      int len;
      stop_at = words_sent + words;
      while (words_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            len = $urandom_range(4, 40);
            send_unit(len, len, random_ts());
         end else if (pick < 78) begin
            len = $urandom_range(60, 120);
            send_unit(len, len, random_ts());
         end else if (pick < 88) begin
            len = $urandom_range(0, 3);
            send_unit(len, (len == 0) ? 1 : len, random_ts());
         end else if (pick < 95) begin
            len = $urandom_range(6, 40);
            send_unit(len, $urandom_range(1, len - 1), random_ts());
         end else begin
            send_body(8'($urandom()));
         end
      end
   endtask

   initial begin : stimulus
      pack_model        = new();
      calm              = 0;
      long_hold_request = 0;
      words_sent        = 0;
      reset            <= 1'b1;
      req.valid        <= 1'b0;
      req.data_byte    <= '0;
      req.unit_start   <= 1'b0;
      req.unit_length  <= '0;
      req.timestamp_ns <= '0;
      csr.valid        <= 1'b0;
      csr.substream_id <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part with the reset substream id. First a stray byte with no unit
      // open, then minimal units at the timestamp extremes and data extremes.
      send_body(8'hFF);
      send_word(8'h00, 1'b1, 16'd4, 58'd0);
      send_body(8'hFF);
      send_body(8'h00);
      send_body(8'hFF);
      send_word(8'hFF, 1'b1, 16'd4, {58{1'b1}});
      send_body(8'h00);
      send_body(8'hFF);
      send_body(8'h5A);
      // Short units are swallowed along with their remaining bytes.
      send_unit(0, 1, random_ts());
      send_unit(1, 1, random_ts());
      send_unit(3, 3, random_ts());
      // An early restart drops the tail of the open unit.
      send_unit(10, 3, random_ts());
      send_unit(5, 5, random_ts());
      send_unit(16'hFFFF, 1, random_ts());
      drain();

      // High extreme of the substream id, with one long receiver hold-off while the
      // sender keeps offering words.
      write_substream_id(6'd63);
      long_hold_request = 1;
      send_unit(100, 100, random_ts());
      random_units(60);
      drain();

      // Substream id 32, plus units whose first pack ends near the edge: small spare as
      // stuffing, exactly six spare bytes, and one that spills into a second pack.
      // Each is cut short by the next unit, so their headers are what gets checked.
      write_substream_id(6'd32);
      send_unit(sps_pkg::ROOM_FIRST - 3, 3, random_ts());
      send_unit(sps_pkg::ROOM_FIRST - 6, 3, random_ts());
      send_unit(sps_pkg::ROOM_FIRST + 6, 3, random_ts());
      random_units(60);
      drain();

      // Random id, and a final stretch with no idling on either side.
      write_substream_id(6'($urandom_range(32, 63)));
      random_units(40);
      calm = 1;
      random_units(40);
      drain();

      if (pack_model.stream_words.size() != 0) begin
         $error("%0d predicted words never came out", pack_model.stream_words.size());
         pack_model.errors++;
      end
      if (pack_model.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/sps_pkg.sv
hdl/sps_ifs.sv
hdl/sps_front.sv
hdl/sps_queue.sv
hdl/sps_back.sv
hdl/subtitle_ps_pack_framer.sv
hdl/sps_checker.sv
sim/subtitle_ps_pack_framer_test.sv
